/* design/chps_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and cut arithmetic for the corner-cutting polyline smoother.
// Used by every module of the block; depends on nothing.
package chps_pkg;

  localparam int MAX_PASSES  = 4;
  localparam int ACT_W       = 3;   // holds 0 .. MAX_PASSES
  localparam int CFG_W       = 3;
  localparam int COORD_W     = 32;
  localparam int RADIUS_W    = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Points of the polyline seen so far, saturating at two
  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_MANY = 2'd2;

  // Phases of a cutting pass on one point
  localparam logic [1:0] PH_NEAR_PREV = 2'd0;
  localparam logic [1:0] PH_NEAR_CUR  = 2'd1;
  localparam logic [1:0] PH_TAIL      = 2'd2;

  // One point on its way through the passes; act is the number of passes that
  // cut it, zero for a point that goes through raw.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [RADIUS_W-1:0]       r;
    logic                      last;
    logic [ACT_W-1:0]          act;
  } item_t;

  // floor((3a + b) / 4) on signed coordinates
  function automatic logic [COORD_W-1:0] cut_coord(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
    logic [COORD_W+1:0] ae;
    logic [COORD_W+1:0] be;
    logic [COORD_W+1:0] t;
    ae = {{2{a[COORD_W-1]}}, a};
    be = {{2{b[COORD_W-1]}}, b};
    t  = ae + {ae[COORD_W:0], 1'b0} + be;
    return t[COORD_W+1:2];
  endfunction

  // floor((3a + b) / 4) on unsigned radii
  function automatic logic [RADIUS_W-1:0] cut_radius(input logic [RADIUS_W-1:0] a,
                                                     input logic [RADIUS_W-1:0] b);
    logic [RADIUS_W+1:0] t;
    t = {2'b00, a} + {1'b0, a, 1'b0} + {2'b00, b};
    return t[RADIUS_W+1:2];
  endfunction

endpackage

/* design/chps_front.sv */
`timescale 1ns / 1ps
// Front end: input transfer, pass count register and per-point classification.
// Depends on chps_pkg; feeds chps_queue.
module chps_front import chps_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic [RADIUS_W-1:0]        point_radius,
  input  logic                       point_last,
  input  logic                       cfg_wr_en,
  input  logic [CFG_W-1:0]           cfg_wr_data,
  input  logic                       q_full,
  output logic                       q_wr_en,
  output item_t                      q_wr_data
);

  logic [CFG_W-1:0] pass_count;
  logic [1:0]       point_cnt;
  logic [ACT_W-1:0] act_clamped;
  logic             raw_pair_end;
  logic             accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_wr_en  = accept;

  // Clamp the pass count into 1 .. MAX_PASSES
  always_comb begin
    if (pass_count == '0) begin
      act_clamped = ACT_W'(1);
    end else if (pass_count > CFG_W'(MAX_PASSES)) begin
      act_clamped = ACT_W'(MAX_PASSES);
    end else begin
      act_clamped = ACT_W'(pass_count);
    end
  end

  // A two-point polyline ends raw: no pass cuts its second point
  assign raw_pair_end = point_last && (point_cnt == CNT_ONE);

  always_comb begin
    q_wr_data.x    = point_x;
    q_wr_data.y    = point_y;
    q_wr_data.r    = point_radius;
    q_wr_data.last = point_last;
    q_wr_data.act  = raw_pair_end ? '0 : act_clamped;
  end

  // Hold the pass count and count points of the current polyline
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= CFG_W'(1);
      point_cnt  <= CNT_NONE;
    end else begin
      if (cfg_wr_en) begin
        pass_count <= cfg_wr_data;
      end
      if (accept) begin
        if (point_last) begin
          point_cnt <= CNT_NONE;
        end else if (point_cnt == CNT_NONE) begin
          point_cnt <= CNT_ONE;
        end else begin
          point_cnt <= CNT_MANY;
        end
      end
    end
  end

endmodule

/* design/chps_queue.sv */
`timescale 1ns / 1ps
// Short FIFO that decouples the classifying front end from the cutting passes.
// Depends on chps_pkg.
module chps_queue import chps_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_en,
  input  item_t  wr_data,
  output logic   full,
  output logic   rd_valid,
  input  logic   rd_stall,
  output item_t  rd_data
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              rd_take;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign rd_take  = rd_valid && !rd_stall;

  // Store payload
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (rd_take) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (wr_en && !rd_take) begin
        count <= count + QCNT_W'(1);
      end else if (rd_take && !wr_en) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

/* design/chps_pass.sv */
`timescale 1ns / 1ps
// One corner-cutting pass: holds the prior point and, unless stalled, emits the
// cut points of each segment one per cycle, registered. Depends on chps_pkg.
module chps_pass import chps_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [ACT_W-1:0] pass_idx,
  input  logic             up_valid,
  output logic             up_stall,
  input  item_t            up_data,
  output logic             dn_valid,
  input  logic             dn_stall,
  output item_t            dn_data
);

  item_t               cur;
  logic                cur_valid;
  logic [1:0]          phase;
  logic [COORD_W-1:0]  prev_x;
  logic [COORD_W-1:0]  prev_y;
  logic [RADIUS_W-1:0] prev_r;
  logic                has_prev;
  item_t               obuf;
  logic                obuf_valid;

  logic  active;
  logic  cutting;
  logic  load_ok;
  logic  emit;
  logic  done;
  logic  fin;
  logic  up_take;
  item_t emit_pt;

  assign active   = (pass_idx < cur.act);
  assign cutting  = active && has_prev;
  assign load_ok  = !obuf_valid || !dn_stall;
  assign emit     = cur_valid && load_ok;
  assign fin      = emit && done;
  assign up_stall = cur_valid && !fin;
  assign up_take  = up_valid && !up_stall;
  assign dn_valid = obuf_valid;
  assign dn_data  = obuf;

  // Select the point to emit in this phase
  always_comb begin
    emit_pt = cur;
    done    = 1'b1;
    if (cutting) begin
      unique case (phase)
        PH_NEAR_PREV: begin
          emit_pt.x    = cut_coord(prev_x, cur.x);
          emit_pt.y    = cut_coord(prev_y, cur.y);
          emit_pt.r    = cut_radius(prev_r, cur.r);
          emit_pt.last = 1'b0;
          done         = 1'b0;
        end
        PH_NEAR_CUR: begin
          emit_pt.x    = cut_coord(cur.x, prev_x);
          emit_pt.y    = cut_coord(cur.y, prev_y);
          emit_pt.r    = cut_radius(cur.r, prev_r);
          emit_pt.last = 1'b0;
          done         = !cur.last;
        end
        default: begin
          emit_pt = cur;
          done    = 1'b1;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (up_take) begin
      cur <= up_data;
    end
    if (emit) begin
      obuf <= emit_pt;
    end
    if (fin && active) begin
      prev_x <= cur.x;
      prev_y <= cur.y;
      prev_r <= cur.r;
    end
  end

  // Control: phase, occupancy and held-point flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      phase      <= PH_NEAR_PREV;
      has_prev   <= 1'b0;
      obuf_valid <= 1'b0;
    end else begin
      if (load_ok) begin
        obuf_valid <= emit;
      end
      if (fin) begin
        phase <= PH_NEAR_PREV;
        if (active) begin
          has_prev <= !cur.last;
        end else if (cur.last) begin
          has_prev <= 1'b0;
        end
      end else if (emit) begin
        phase <= (phase == PH_NEAR_PREV) ? PH_NEAR_CUR : PH_TAIL;
      end
      if (up_take) begin
        cur_valid <= 1'b1;
      end else if (fin) begin
        cur_valid <= 1'b0;
      end
    end
  end

endmodule

/* design/chaikin_polyline_smoother_unit.sv */
`timescale 1ns / 1ps
// Top level of the corner-cutting polyline smoother: front end, queue and passes.
// Depends on chps_pkg, chps_front, chps_queue and chps_pass.

// Smooths an open polyline with 1 to 4 cascaded corner-cutting passes (pass count
// register, 0 acts as 1, above 4 acts as 4). Each pass keeps the end points and
// replaces every segment by its quarter and three-quarter points; a polyline of one
// or two points comes out unchanged, and out_last marks its final result. The block
// delivers at most one result per clock, from the output register of the last pass;
// an interior point yields 2^passes results (16 with four passes), a first point
// yields one, and a final point 2^(passes+1) - 1. A four-entry queue lets points be
// transferred in while earlier ones are still being cut; an input point reaches the
// output through the queue and the current-point and output registers of each pass.
// Write the pass count only while the block is idle.
module chaikin_polyline_smoother_unit import chps_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [CFG_W-1:0]           cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [COORD_W-1:0]  point_x,
  input  logic signed [COORD_W-1:0]  point_y,
  input  logic [RADIUS_W-1:0]        point_radius,
  input  logic                       point_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COORD_W-1:0]  out_x,
  output logic signed [COORD_W-1:0]  out_y,
  output logic [RADIUS_W-1:0]        out_radius,
  output logic                       out_last
);

  logic  q_full;
  logic  q_wr_en;
  item_t q_wr_data;

  logic  link_valid [MAX_PASSES+1];
  logic  link_stall [MAX_PASSES+1];
  item_t link_data  [MAX_PASSES+1];

  // Accept and classify points
  chps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_radius (point_radius),
    .point_last   (point_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .q_full       (q_full),
    .q_wr_en      (q_wr_en),
    .q_wr_data    (q_wr_data)
  );

  // Buffer classified points
  chps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_wr_en),
    .wr_data  (q_wr_data),
    .full     (q_full),
    .rd_valid (link_valid[0]),
    .rd_stall (link_stall[0]),
    .rd_data  (link_data[0])
  );

  // Cascade of cutting passes
  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_pass
    chps_pass u_pass (
      .clk      (clk),
      .rst      (rst),
      .pass_idx (ACT_W'(s)),
      .up_valid (link_valid[s]),
      .up_stall (link_stall[s]),
      .up_data  (link_data[s]),
      .dn_valid (link_valid[s+1]),
      .dn_stall (link_stall[s+1]),
      .dn_data  (link_data[s+1])
    );
  end

  // Drive the result channel from the last pass
  assign link_stall[MAX_PASSES] = out_stall;
  assign out_valid  = link_valid[MAX_PASSES];
  assign out_x      = link_data[MAX_PASSES].x;
  assign out_y      = link_data[MAX_PASSES].y;
  assign out_radius = link_data[MAX_PASSES].r;
  assign out_last   = link_data[MAX_PASSES].last;

endmodule

/* design/chps_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the polyline smoother, bound to its top level.
// Depends on chps_pkg and chaikin_polyline_smoother_unit.
module chps_checker import chps_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [COORD_W-1:0] out_x,
  input logic signed [COORD_W-1:0] out_y,
  input logic [RADIUS_W-1:0]       out_radius,
  input logic                      out_last
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_radius) && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the block: no result and room for input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // No result can appear in the first cycles after reset
  a_reset_latency: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("result too soon after reset");

  // The input can only start stalling after an input transfer fills the queue
  a_stall_needs_transfer: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall) |=> !$rose(in_stall))
    else $error("input stall rose without a transfer");

endmodule

bind chaikin_polyline_smoother_unit chps_checker u_chps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_x      (out_x),
  .out_y      (out_y),
  .out_radius (out_radius),
  .out_last   (out_last)
);
